@@ sv/mmepq_pkg.sv @@
// ----------------------------------------------------------------------------
// mmepq_pkg - shared types and constants
// Operation and status codes, controller state and command/status structs
// for the min/max extract priority queue.
// ----------------------------------------------------------------------------
package mmepq_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int OP_W          = 2;
    localparam int VAL_W         = 32;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 6;

    localparam logic [OP_W-1:0] OP_INSERT     = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE_MIN = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_MAX = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR      = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;       // latch op, do insert or clear
        logic scan_start;   // reset scan pointer
        logic scan_step;    // issue a read, compare returned entry
        logic shift_start;  // point past the removed entry
        logic shift_step;   // move one entry down
        logic finish;       // load result register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_scan;    // presented op is a remove on a non-empty store
        logic scan_done;
        logic shift_done;
        logic out_free;     // result register can take a new transaction
    } dp_status_t;

endpackage

@@ sv/min_max_extract_priority_queue.sv @@
// ----------------------------------------------------------------------------
// min_max_extract_priority_queue - double-ended priority queue, top level
// Bounded store of signed 32-bit values kept in insertion order. Supports
// insert, remove-smallest, remove-largest and clear; one result per
// transaction.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata                        tuser
//  -------  ---  ---------------------------  -------------------------
//  s_       in   [31:0] value_in              [1:0] op
//  m_       out  [31:0] value_out,            [1:0] status
//                [37:32] count, [39:38] zero
//
//  Steps: insert, clear and refused ops take an accept step and a result step.
//  A remove runs the accept step, then a scan pass (one read per entry, the
//  registered read of the entry memory, a done check), then a shift pass
//  that moves each entry after the extreme one place down (none when it is
//  the last entry), then the result step; both passes use the single read port.
//  Reset: synchronous, active low; clears the count and handshakes. Entry
//  contents are not cleared and need no clearing pass.
//  Stalls: a finished result sits in the output register; the next input
//  transaction is taken while it waits, and the new op holds in its final
//  step until m_tready frees the register.
//
module min_max_extract_priority_queue
    import mmepq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] value_in
    input  logic [1:0]  s_tuser,    // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [31:0] value_out, [37:32] count, [39:38] zero
    output logic [1:0]  m_tuser     // [1:0] status
);

    dp_cmd_t    cmd;
    dp_status_t st;

    logic [STATUS_W-1:0] res_status;
    logic [VAL_W-1:0]    res_value;
    logic [COUNT_W-1:0]  res_count;

    // sequencer: idle / scan / shift / finish
    mmepq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // entry memory, scan compare, shift and result register
    mmepq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_op     (s_tuser),
        .s_value  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_status (res_status),
        .m_value  (res_value),
        .m_count  (res_count),
        .cmd      (cmd),
        .st       (st)
    );

    assign m_tdata = {2'b00, res_count, res_value};
    assign m_tuser = res_status;

endmodule

@@ sv/mmepq_ctrl.sv @@
// ----------------------------------------------------------------------------
// mmepq_ctrl - sequencing controller
// Accepts one operation at a time, steps the datapath through the scan and
// shift passes of a remove, and hands off the result.
// ----------------------------------------------------------------------------
module mmepq_ctrl
    import mmepq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (st.need_scan) begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN: begin
                if (st.scan_done) begin
                    cmd.shift_start = 1'b1;
                    state_next      = S_SHIFT;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_SHIFT: begin
                if (st.shift_done) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_FINISH: begin
                if (st.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/mmepq_datapath.sv @@
// ----------------------------------------------------------------------------
// mmepq_datapath - entry store, scan and shift logic, result register
// One-write, one-read entry memory with registered read data; pointers for
// the extreme-value scan and the tail shift.
// ----------------------------------------------------------------------------
module mmepq_datapath
    import mmepq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [OP_W-1:0]     s_op,
    input  logic [VAL_W-1:0]    s_value,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [STATUS_W-1:0] m_status,
    output logic [VAL_W-1:0]    m_value,
    output logic [COUNT_W-1:0]  m_count,
    input  dp_cmd_t             cmd,
    output dp_status_t          st
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [VAL_W-1:0] mem [DEPTH];

    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [STATUS_W-1:0] stat_reg, stat_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic                rdv_reg, rdv_next;
    logic [AW-1:0]       rdidx_reg, rdidx_next;
    logic [VAL_W-1:0]    rd_data_reg;
    logic [VAL_W-1:0]    best_reg, best_next;
    logic [AW-1:0]       bidx_reg, bidx_next;
    logic                mv_reg, mv_next;
    logic [STATUS_W-1:0] ms_reg, ms_next;
    logic [VAL_W-1:0]    mval_reg, mval_next;
    logic [COUNT_W-1:0]  mcnt_reg, mcnt_next;

    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [VAL_W-1:0]    wr_data;

    logic is_full, is_empty, is_remove, in_remove, take;

    assign is_full   = (cnt_reg >= DEPTH_C);
    assign is_empty  = (cnt_reg == '0);
    assign in_remove = (s_op == OP_REMOVE_MIN) || (s_op == OP_REMOVE_MAX);
    assign is_remove = (op_reg == OP_REMOVE_MIN) || (op_reg == OP_REMOVE_MAX);

    // strict compare keeps the earliest of equal extremes
    always_comb begin
        if (rdidx_reg == '0) begin
            take = 1'b1;
        end else if (op_reg == OP_REMOVE_MAX) begin
            take = $signed(rd_data_reg) > $signed(best_reg);
        end else begin
            take = $signed(rd_data_reg) < $signed(best_reg);
        end
    end

    always_comb begin
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        stat_next  = stat_reg;
        ptr_next   = ptr_reg;
        rdv_next   = rdv_reg;
        rdidx_next = rdidx_reg;
        best_next  = best_reg;
        bidx_next  = bidx_reg;
        mv_next    = mv_reg;
        ms_next    = ms_reg;
        mval_next  = mval_reg;
        mcnt_next  = mcnt_reg;
        rd_en      = 1'b0;
        rd_addr    = ptr_reg[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = cnt_reg[AW-1:0];
        wr_data    = s_value;

        if (cmd.accept) begin
            op_next   = s_op;
            stat_next = ST_OK;
            case (s_op)
                OP_INSERT: begin
                    if (is_full) begin
                        stat_next = ST_FULL;
                    end else begin
                        wr_en    = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                OP_REMOVE_MIN, OP_REMOVE_MAX: begin
                    if (is_empty) begin
                        stat_next = ST_EMPTY;
                    end
                end
                default: begin
                    cnt_next = '0;
                end
            endcase
        end

        if (cmd.scan_start) begin
            ptr_next = '0;
            rdv_next = 1'b0;
        end

        if (cmd.scan_step || cmd.shift_step) begin
            if (ptr_reg < cnt_reg) begin
                rd_en      = 1'b1;
                rdv_next   = 1'b1;
                rdidx_next = ptr_reg[AW-1:0];
                ptr_next   = ptr_reg + 1'b1;
            end else begin
                rdv_next = 1'b0;
            end
        end

        if (cmd.scan_step && rdv_reg && take) begin
            best_next = rd_data_reg;
            bidx_next = rdidx_reg;
        end

        if (cmd.shift_start) begin
            ptr_next = CW'(bidx_reg) + 1'b1;
            rdv_next = 1'b0;
        end

        // entry read last cycle moves one place down
        if (cmd.shift_step && rdv_reg) begin
            wr_en   = 1'b1;
            wr_addr = rdidx_reg - 1'b1;
            wr_data = rd_data_reg;
        end

        if (m_tready) begin
            mv_next = 1'b0;
        end
        if (cmd.finish) begin
            mv_next = 1'b1;
            ms_next = stat_reg;
            if (is_remove && stat_reg == ST_OK) begin
                mval_next = best_reg;
                cnt_next  = cnt_reg - 1'b1;
                mcnt_next = COUNT_W'(cnt_reg - 1'b1);
            end else begin
                mval_next = '0;
                mcnt_next = COUNT_W'(cnt_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rdv_reg <= 1'b0;
            mv_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            rdv_reg <= rdv_next;
            mv_reg  <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        stat_reg  <= stat_next;
        ptr_reg   <= ptr_next;
        rdidx_reg <= rdidx_next;
        best_reg  <= best_next;
        bidx_reg  <= bidx_next;
        ms_reg    <= ms_next;
        mval_reg  <= mval_next;
        mcnt_reg  <= mcnt_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign st.need_scan  = in_remove && !is_empty;
    assign st.scan_done  = (ptr_reg >= cnt_reg) && !rdv_reg;
    assign st.shift_done = (ptr_reg >= cnt_reg) && !rdv_reg;
    assign st.out_free   = !mv_reg || m_tready;

    assign m_tvalid = mv_reg;
    assign m_status = ms_reg;
    assign m_value  = mval_reg;
    assign m_count  = mcnt_reg;

endmodule
